// File: rtl/radix2_dif_fft_defines.svh
// Assertion macros shared by the FFT RTL.
`ifndef RADIX2_DIF_FFT_DEFINES_SVH
`define RADIX2_DIF_FFT_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define R2FFT_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition must never be true outside reset.
`define R2FFT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// File: rtl/r2fft_pkg.sv
// Shared types, codes and twiddle generation for the radix-2 DIF FFT.
package r2fft_pkg;

   localparam int OP_W   = 2;
   localparam int IDX_W  = 10;
   localparam int PT_W   = 16;
   localparam int WORD_W = 27;
   localparam int TW_W   = 18;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_XFORM = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [63:0] ONE_Q62    = 64'h4000000000000000;
   localparam logic [63:0] HALFPI_Q62 = 64'h6487ED5110B4611A;

   // read tag that travels with each memory read into the butterfly
   typedef struct packed {
      logic valid;
      logic lower;
      logic swap;
   } tag_type;

   function automatic logic [63:0] mulq62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // {cos, sin} of (pi/2)*k/(N/4) as rounded Q1.16, evaluated at elaboration
   function automatic logic [35:0] trig_q16(input logic [63:0] k, input int log2n);
      logic [63:0] f;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] ss;
      logic [63:0] tc;
      logic [63:0] sc;
      logic [63:0] rs;
      logic [63:0] rc;
      f  = k << (64 - log2n);
      x  = mulq62(HALFPI_Q62, f);
      x2 = mulq62(x, x);
      ts = x;
      ss = x;
      tc = ONE_Q62;
      sc = ONE_Q62;
      for (int i = 1; i <= 14; i++) begin
         ts = mulq62(ts, x2) / 64'((2 * i) * (2 * i + 1));
         tc = mulq62(tc, x2) / 64'((2 * i - 1) * (2 * i));
         if ((i % 2) == 1) begin
            ss = ss - ts;
            sc = sc - tc;
         end else begin
            ss = ss + ts;
            sc = sc + tc;
         end
      end
      rs = ss + (64'd1 << 45);
      rc = sc + (64'd1 << 45);
      return {rc[63:46], rs[63:46]};
   endfunction

endpackage

// File: rtl/radix2_dif_fft.sv
// Top level of the radix-2 DIF FFT: command sequencer, memories and response queue.
//
//   channel  dir  handshake              beat
//   req      in   req_valid/req_ready    operation, index, point_re, point_im
//   rsp      out  rsp_valid/rsp_ready    bin_re, bin_im (read only)
//
// A read's bin passes through the registered memory read and the response queue before rsp offers it.
// Transform: LOG2_POINTS butterfly stages, each drained before the next, then a
// bit-reverse reorder pass that swaps each pair once; the single memory read port
// (one word per cycle) sets its length.
// Reset clears control only; memory contents are undefined until loaded.
// req_ready drops during a transform and while two read beats wait on rsp.
`include "radix2_dif_fft_defines.svh"

module radix2_dif_fft #(
   parameter int LOG2_POINTS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [r2fft_pkg::OP_W-1:0]           req_operation,
   input  logic [r2fft_pkg::IDX_W-1:0]          req_index,
   input  logic signed [r2fft_pkg::PT_W-1:0]    req_point_re,
   input  logic signed [r2fft_pkg::PT_W-1:0]    req_point_im,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [r2fft_pkg::WORD_W-1:0]  rsp_bin_re,
   output logic signed [r2fft_pkg::WORD_W-1:0]  rsp_bin_im
);

   localparam int AW = LOG2_POINTS;
   localparam int HW = LOG2_POINTS - 1;
   localparam int SW = $clog2(LOG2_POINTS);
   localparam int W  = r2fft_pkg::WORD_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_BFLY  = 3'd1;
   localparam logic [2:0] ST_BWAIT = 3'd2;
   localparam logic [2:0] ST_SWAP  = 3'd3;
   localparam logic [2:0] ST_SWAIT = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [SW-1:0]       st_ff, st_in;
   logic [HW-1:0]       bcnt_ff, bcnt_in;
   logic [AW-1:0]       scnt_ff, scnt_in;
   logic                ph_ff, ph_in;
   r2fft_pkg::tag_type  tag_ff, tag_in;
   logic [AW-1:0]       tag_addr_ff, tag_addr_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic signed [W-1:0] q0_re_ff, q0_im_ff, q1_re_ff, q1_im_ff;

   logic                accept, pop, push, busy;
   logic [1:0]          after_pop;
   logic [AW-1:0]       req_addr, up_a, lo_a, lowmask, bw, rev;
   logic [SW-1:0]       s_sel;
   logic [HW-1:0]       tidx;
   logic                tw_en;

   logic                rd_en, wr_en, bf_wr_en;
   logic [AW-1:0]       rd_addr, wr_addr, bf_wr_addr;
   logic signed [W-1:0] wr_re, wr_im, bf_wr_re, bf_wr_im, rd_re, rd_im;
   logic signed [r2fft_pkg::TW_W-1:0] tw_re, tw_im;
   logic                ld_en;

   assign req_addr = AW'(req_index);
   assign pop      = rsp_valid && rsp_ready;
   assign push     = rd_pend_ff;
   assign accept   = req_valid && req_ready;
   assign after_pop = cnt_ff - {1'b0, pop};

   always_comb begin
      req_ready = (state_ff == ST_IDLE) && ((3'(cnt_ff) + 3'(rd_pend_ff) - 3'(pop)) < 3'd2);
   end

   always_comb begin
      s_sel   = SW'(AW - 1) - st_ff;
      lowmask = (AW'(1) << s_sel) - AW'(1);
      bw      = AW'(bcnt_ff);
      up_a    = ((bw & ~lowmask) << 1) | (bw & lowmask);
      lo_a    = up_a | (AW'(1) << s_sel);
      tidx    = HW'((bw & lowmask) << st_ff);
      for (int b = 0; b < AW; b++) begin
         rev[b] = scnt_ff[AW-1-b];
      end
   end

   always_comb begin
      state_in    = state_ff;
      st_in       = st_ff;
      bcnt_in     = bcnt_ff;
      scnt_in     = scnt_ff;
      ph_in       = ph_ff;
      tag_in      = '0;
      tag_addr_in = tag_addr_ff;
      rd_en       = 1'b0;
      rd_addr     = req_addr;
      rd_pend_in  = 1'b0;
      ld_en       = 1'b0;
      tw_en       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  r2fft_pkg::OP_LOAD: begin
                     ld_en = 1'b1;
                  end
                  r2fft_pkg::OP_XFORM: begin
                     state_in = ST_BFLY;
                     st_in    = '0;
                     bcnt_in  = '0;
                     ph_in    = 1'b0;
                  end
                  r2fft_pkg::OP_READ: begin
                     rd_en      = 1'b1;
                     rd_pend_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_BFLY: begin
            rd_en        = 1'b1;
            tag_in.valid = 1'b1;
            tag_in.lower = ph_ff;
            if (!ph_ff) begin
               rd_addr     = up_a;
               tag_addr_in = up_a;
               tw_en       = 1'b1;
               ph_in       = 1'b1;
            end else begin
               rd_addr     = lo_a;
               tag_addr_in = lo_a;
               ph_in       = 1'b0;
               bcnt_in     = bcnt_ff + HW'(1);
               if (bcnt_ff == '1) begin
                  state_in = ST_BWAIT;
               end
            end
         end
         ST_BWAIT: begin
            if (!busy) begin
               if (st_ff == SW'(AW - 1)) begin
                  state_in = ST_SWAP;
                  scnt_in  = '0;
                  ph_in    = 1'b0;
               end else begin
                  state_in = ST_BFLY;
                  st_in    = st_ff + SW'(1);
                  bcnt_in  = '0;
               end
            end
         end
         ST_SWAP: begin
            if (ph_ff) begin
               rd_en        = 1'b1;
               rd_addr      = rev;
               tag_addr_in  = rev;
               tag_in.valid = 1'b1;
               tag_in.lower = 1'b1;
               tag_in.swap  = 1'b1;
               ph_in        = 1'b0;
            end else if (scnt_ff < rev) begin
               rd_en        = 1'b1;
               rd_addr      = scnt_ff;
               tag_addr_in  = scnt_ff;
               tag_in.valid = 1'b1;
               tag_in.swap  = 1'b1;
               ph_in        = 1'b1;
            end
            if (ph_ff || !(scnt_ff < rev)) begin
               scnt_in = scnt_ff + AW'(1);
               if (scnt_ff == '1) begin
                  state_in = ST_SWAIT;
               end
            end
         end
         ST_SWAIT: begin
            if (!busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      wr_en   = ld_en || bf_wr_en;
      wr_addr = ld_en ? req_addr : bf_wr_addr;
      wr_re   = ld_en ? W'(req_point_re) : bf_wr_re;
      wr_im   = ld_en ? W'(req_point_im) : bf_wr_im;
   end

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         st_ff      <= '0;
         bcnt_ff    <= '0;
         scnt_ff    <= '0;
         ph_ff      <= 1'b0;
         tag_ff     <= '0;
         rd_pend_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         st_ff      <= st_in;
         bcnt_ff    <= bcnt_in;
         scnt_ff    <= scnt_in;
         ph_ff      <= ph_in;
         tag_ff     <= tag_in;
         rd_pend_ff <= rd_pend_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_addr_ff <= tag_addr_in;
      if (pop && (cnt_ff == 2'd2)) begin
         q0_re_ff <= q1_re_ff;
         q0_im_ff <= q1_im_ff;
      end
      if (push) begin
         if (after_pop == 2'd0) begin
            q0_re_ff <= rd_re;
            q0_im_ff <= rd_im;
         end else begin
            q1_re_ff <= rd_re;
            q1_im_ff <= rd_im;
         end
      end
   end

   assign rsp_valid  = (cnt_ff != 2'd0);
   assign rsp_bin_re = q0_re_ff;
   assign rsp_bin_im = q0_im_ff;

   r2fft_ram #(.LOG2_POINTS(LOG2_POINTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_re   (wr_re),
      .wr_im   (wr_im),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_re   (rd_re),
      .rd_im   (rd_im)
   );

   r2fft_twiddle #(.LOG2_POINTS(LOG2_POINTS)) u_twiddle (
      .clock   (clock),
      .rd_en   (tw_en),
      .rd_addr (tidx),
      .tw_re   (tw_re),
      .tw_im   (tw_im)
   );

   r2fft_bfly #(.LOG2_POINTS(LOG2_POINTS)) u_bfly (
      .clock    (clock),
      .reset    (reset),
      .tag      (tag_ff),
      .tag_addr (tag_addr_ff),
      .rd_re    (rd_re),
      .rd_im    (rd_im),
      .tw_re    (tw_re),
      .tw_im    (tw_im),
      .wr_en    (bf_wr_en),
      .wr_addr  (bf_wr_addr),
      .wr_re    (bf_wr_re),
      .wr_im    (bf_wr_im),
      .busy     (busy)
   );

   `R2FFT_NEVER(a_queue_overflow, cnt_ff == 2'd3, "response queue overflow")
   `R2FFT_CHECK(a_push_has_room, rd_pend_ff |-> cnt_ff != 2'd2, "read beat with no room")
   `R2FFT_CHECK(a_ready_when_drained, req_ready |-> !busy, "accepting while butterflies run")

endmodule

// File: rtl/r2fft_ram.sv
// Work memory: one write port, one registered read port, real and imaginary words.
module r2fft_ram #(
   parameter int LOG2_POINTS = 10,
   localparam int DEPTH = 2 ** LOG2_POINTS
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [LOG2_POINTS-1:0]                wr_addr,
   input  logic signed [r2fft_pkg::WORD_W-1:0]   wr_re,
   input  logic signed [r2fft_pkg::WORD_W-1:0]   wr_im,
   input  logic                                  rd_en,
   input  logic [LOG2_POINTS-1:0]                rd_addr,
   output logic signed [r2fft_pkg::WORD_W-1:0]   rd_re,
   output logic signed [r2fft_pkg::WORD_W-1:0]   rd_im
);

   logic signed [r2fft_pkg::WORD_W-1:0] mem_re [DEPTH];
   logic signed [r2fft_pkg::WORD_W-1:0] mem_im [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_re[wr_addr] <= wr_re;
         mem_im[wr_addr] <= wr_im;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_re <= mem_re[rd_addr];
         rd_im <= mem_im[rd_addr];
      end
   end

endmodule

// File: rtl/r2fft_twiddle.sv
// Twiddle ROM, N/2 entries of Q1.16 cos/-sin pairs, registered read.
module r2fft_twiddle #(
   parameter int LOG2_POINTS = 10,
   localparam int HW    = LOG2_POINTS - 1,
   localparam int HALF  = 2 ** (LOG2_POINTS - 1),
   localparam int QUART = HALF / 2
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [HW-1:0]                        rd_addr,
   output logic signed [r2fft_pkg::TW_W-1:0]    tw_re,
   output logic signed [r2fft_pkg::TW_W-1:0]    tw_im
);

   typedef logic [2*r2fft_pkg::TW_W-1:0] rom_type [HALF];

   function automatic rom_type build_rom();
      rom_type r;
      logic [35:0] t;
      logic [17:0] c;
      logic [17:0] s;
      for (int k = 0; k < HALF; k++) begin
         if (k <= QUART) begin
            t = r2fft_pkg::trig_q16(64'(k), LOG2_POINTS);
            c = t[35:18];
            s = t[17:0];
            r[k] = {c, 18'd0 - s};
         end else begin
            t = r2fft_pkg::trig_q16(64'(k - QUART), LOG2_POINTS);
            c = t[35:18];
            s = t[17:0];
            r[k] = {18'd0 - s, 18'd0 - c};
         end
      end
      return r;
   endfunction

   localparam rom_type TW_ROM = build_rom();

   always_ff @(posedge clock) begin
      if (rd_en) begin
         tw_re <= signed'(TW_ROM[rd_addr][35:18]);
         tw_im <= signed'(TW_ROM[rd_addr][17:0]);
      end
   end

endmodule

// File: rtl/r2fft_bfly.sv
// Butterfly datapath: pairs reads, sum/difference, twiddle multiply, write-back; swap reads are written back exchanged.
`include "radix2_dif_fft_defines.svh"

module r2fft_bfly #(
   parameter int LOG2_POINTS = 10,
   localparam int AW = LOG2_POINTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  r2fft_pkg::tag_type                   tag,
   input  logic [AW-1:0]                        tag_addr,
   input  logic signed [r2fft_pkg::WORD_W-1:0]  rd_re,
   input  logic signed [r2fft_pkg::WORD_W-1:0]  rd_im,
   input  logic signed [r2fft_pkg::TW_W-1:0]    tw_re,
   input  logic signed [r2fft_pkg::TW_W-1:0]    tw_im,
   output logic                                 wr_en,
   output logic [AW-1:0]                        wr_addr,
   output logic signed [r2fft_pkg::WORD_W-1:0]  wr_re,
   output logic signed [r2fft_pkg::WORD_W-1:0]  wr_im,
   output logic                                 busy
);

   localparam int W = r2fft_pkg::WORD_W;
   localparam int T = r2fft_pkg::TW_W;
   localparam int P = W + 1 + T;

   function automatic logic signed [P-17:0] rnd16(input logic signed [P-1:0] p);
      logic signed [P-1:0] q;
      q = p + P'(32768);
      return q[P-1:16];
   endfunction

   logic signed [W-1:0] up_re_ff, up_im_ff;
   logic [AW-1:0]       up_addr_ff;

   logic                s1_v_ff, s1_swap_ff;
   logic [AW-1:0]       s1_ua_ff, s1_la_ff;
   logic signed [W-1:0] s1_sr_ff, s1_si_ff;
   logic signed [W:0]   s1_dr_ff, s1_di_ff;
   logic signed [T-1:0] s1_ur_ff, s1_ui_ff;
   logic signed [W:0]   dr_in, di_in, sr_in, si_in;

   logic                s2_v_ff, s2_swap_ff;
   logic [AW-1:0]       s2_ua_ff, s2_la_ff;
   logic signed [W-1:0] s2_sr_ff, s2_si_ff;
   logic signed [W:0]   s2_dr_ff, s2_di_ff;
   logic signed [P-1:0] s2_rr_ff, s2_ii_ff, s2_ri_ff, s2_ir_ff;

   logic                s3_v_ff;
   logic [AW-1:0]       s3_ua_ff, s3_la_ff;
   logic signed [W-1:0] s3_sr_ff, s3_si_ff, s3_lr_ff, s3_li_ff;
   logic signed [P-16:0] lr_in, li_in;

   logic                hold_v_ff;
   logic [AW-1:0]       hold_a_ff;
   logic signed [W-1:0] hold_re_ff, hold_im_ff;

   always_ff @(posedge clock) begin
      if (tag.valid && !tag.lower) begin
         up_re_ff   <= rd_re;
         up_im_ff   <= rd_im;
         up_addr_ff <= tag_addr;
      end
   end

   always_comb begin
      sr_in = (W+1)'(up_re_ff) + (W+1)'(rd_re);
      si_in = (W+1)'(up_im_ff) + (W+1)'(rd_im);
      dr_in = (W+1)'(up_re_ff) - (W+1)'(rd_re);
      di_in = (W+1)'(up_im_ff) - (W+1)'(rd_im);
   end

   always_ff @(posedge clock) begin
      s1_ua_ff   <= up_addr_ff;
      s1_la_ff   <= tag_addr;
      s1_swap_ff <= tag.swap;
      s1_ur_ff   <= tw_re;
      s1_ui_ff   <= tw_im;
      if (tag.swap) begin
         s1_sr_ff <= rd_re;
         s1_si_ff <= rd_im;
         s1_dr_ff <= (W+1)'(up_re_ff);
         s1_di_ff <= (W+1)'(up_im_ff);
      end else begin
         s1_sr_ff <= signed'(sr_in[W-1:0]);
         s1_si_ff <= signed'(si_in[W-1:0]);
         s1_dr_ff <= dr_in;
         s1_di_ff <= di_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ua_ff   <= s1_ua_ff;
      s2_la_ff   <= s1_la_ff;
      s2_swap_ff <= s1_swap_ff;
      s2_sr_ff   <= s1_sr_ff;
      s2_si_ff   <= s1_si_ff;
      s2_dr_ff   <= s1_dr_ff;
      s2_di_ff   <= s1_di_ff;
      s2_rr_ff   <= P'(s1_dr_ff) * P'(s1_ur_ff);
      s2_ii_ff   <= P'(s1_di_ff) * P'(s1_ui_ff);
      s2_ri_ff   <= P'(s1_dr_ff) * P'(s1_ui_ff);
      s2_ir_ff   <= P'(s1_di_ff) * P'(s1_ur_ff);
   end

   always_comb begin
      lr_in = (P-15)'(rnd16(s2_rr_ff)) - (P-15)'(rnd16(s2_ii_ff));
      li_in = (P-15)'(rnd16(s2_ri_ff)) + (P-15)'(rnd16(s2_ir_ff));
   end

   always_ff @(posedge clock) begin
      s3_ua_ff <= s2_ua_ff;
      s3_la_ff <= s2_la_ff;
      s3_sr_ff <= s2_sr_ff;
      s3_si_ff <= s2_si_ff;
      if (s2_swap_ff) begin
         s3_lr_ff <= signed'(s2_dr_ff[W-1:0]);
         s3_li_ff <= signed'(s2_di_ff[W-1:0]);
      end else begin
         s3_lr_ff <= signed'(lr_in[W-1:0]);
         s3_li_ff <= signed'(li_in[W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_v_ff) begin
         hold_a_ff  <= s3_la_ff;
         hold_re_ff <= s3_lr_ff;
         hold_im_ff <= s3_li_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         hold_v_ff <= 1'b0;
      end else begin
         s1_v_ff   <= tag.valid && tag.lower;
         s2_v_ff   <= s1_v_ff;
         s3_v_ff   <= s2_v_ff;
         hold_v_ff <= s3_v_ff;
      end
   end

   always_comb begin
      wr_en = hold_v_ff || s3_v_ff;
      if (hold_v_ff) begin
         wr_addr = hold_a_ff;
         wr_re   = hold_re_ff;
         wr_im   = hold_im_ff;
      end else begin
         wr_addr = s3_ua_ff;
         wr_re   = s3_sr_ff;
         wr_im   = s3_si_ff;
      end
   end

   assign busy = tag.valid || s1_v_ff || s2_v_ff || s3_v_ff || hold_v_ff;

   `R2FFT_CHECK(a_lower_follows_upper, s3_v_ff |=> hold_v_ff, "lower write lost")
   `R2FFT_NEVER(a_write_collision, s3_v_ff && hold_v_ff, "two writes in one cycle")
   `R2FFT_CHECK(a_pair_spacing, s1_v_ff |=> !s1_v_ff, "butterflies closer than two cycles")

endmodule

// File: tb/sv/radix2_dif_fft_checker.sv
// Checker for the radix-2 DIF FFT: watches both channels, predicts bins and compares them.
module radix2_dif_fft_checker
   import r2fft_pkg::*;
#(
   parameter int LOG2_POINTS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [OP_W-1:0]           req_operation,
   input  logic [IDX_W-1:0]          req_index,
   input  logic signed [PT_W-1:0]    req_point_re,
   input  logic signed [PT_W-1:0]    req_point_im,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [WORD_W-1:0]  rsp_bin_re,
   input  logic signed [WORD_W-1:0]  rsp_bin_im,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPTS  = 1 << LOG2_POINTS;
   localparam int NHALF = NPTS >> 1;
   localparam int NQUART = NPTS >> 2;

   typedef struct {
      logic signed [WORD_W-1:0] re;
      logic signed [WORD_W-1:0] im;
   } bin_type;

   logic signed [WORD_W-1:0] spec_re [NPTS];
   logic signed [WORD_W-1:0] spec_im [NPTS];
   longint                   rot_re [NHALF];
   longint                   rot_im [NHALF];
   bin_type                  bins_due [$];
   bin_type                  got_bin;
   bin_type                  want_bin;
   int                       addr;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic logic [63:0] frac62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // cos/sin of (pi/2)*k/(N/4), rounded to Q1.16
   task automatic quarter_trig(input logic [63:0] k, output longint c, output longint s);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] ss;
      logic [63:0] tc;
      logic [63:0] sc;
      x  = frac62_mul(HALFPI_Q62, k << (64 - LOG2_POINTS));
      x2 = frac62_mul(x, x);
      ts = x;
      ss = x;
      tc = ONE_Q62;
      sc = ONE_Q62;
      for (int i = 1; i <= 14; i++) begin
         ts = frac62_mul(ts, x2) / 64'((2 * i) * (2 * i + 1));
         tc = frac62_mul(tc, x2) / 64'((2 * i - 1) * (2 * i));
         if (i % 2 == 1) begin
            ss = ss - ts;
            sc = sc - tc;
         end else begin
            ss = ss + ts;
            sc = sc + tc;
         end
      end
      s = longint'((ss + (64'd1 << 45)) >> 46);
      c = longint'((sc + (64'd1 << 45)) >> 46);
   endtask

   initial begin
      longint c;
      longint s;
      for (int k = 0; k < NHALF; k++) begin
         if (k <= NQUART) begin
            quarter_trig(64'(k), c, s);
            rot_re[k] = c;
            rot_im[k] = -s;
         end else begin
            quarter_trig(64'(k - NQUART), c, s);
            rot_re[k] = -s;
            rot_im[k] = -c;
         end
      end
   end

   function automatic logic signed [WORD_W-1:0] wrap_word(input longint v);
      logic [63:0] t;
      t = v;
      return t[WORD_W-1:0];
   endfunction

   function automatic longint round_q16(input longint p);
      return (p + 32768) >>> 16;
   endfunction

   function automatic int reverse_bits(input int v);
      int r;
      r = 0;
      for (int b = 0; b < LOG2_POINTS; b++) begin
         r = (r << 1) | ((v >> b) & 1);
      end
      return r;
   endfunction

   task automatic compute_spectrum();
      int     half;
      int     span;
      int     stride;
      int     lo;
      int     r;
      longint wr;
      longint wi;
      longint dr;
      longint di;
      logic signed [WORD_W-1:0] t;
      half = NPTS;
      stride = 1;
      for (int st = 0; st < LOG2_POINTS; st++) begin
         span = half;
         half = half >> 1;
         for (int j = 0; j < half; j++) begin
            wr = rot_re[(j * stride) & (NHALF - 1)];
            wi = rot_im[(j * stride) & (NHALF - 1)];
            for (int i = j; i < NPTS; i += span) begin
               lo = i + half;
               dr = longint'(spec_re[i]) - longint'(spec_re[lo]);
               di = longint'(spec_im[i]) - longint'(spec_im[lo]);
               spec_re[i] = wrap_word(longint'(spec_re[i]) + longint'(spec_re[lo]));
               spec_im[i] = wrap_word(longint'(spec_im[i]) + longint'(spec_im[lo]));
               spec_re[lo] = wrap_word(round_q16(dr * wr) - round_q16(di * wi));
               spec_im[lo] = wrap_word(round_q16(dr * wi) + round_q16(di * wr));
            end
         end
         stride = stride << 1;
      end
      for (int i = 0; i < NPTS; i++) begin
         r = reverse_bits(i);
         if (i < r) begin
            t = spec_re[i]; spec_re[i] = spec_re[r]; spec_re[r] = t;
            t = spec_im[i]; spec_im[i] = spec_im[r]; spec_im[r] = t;
         end
      end
   endtask

   task automatic report_bad(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got_bin.re = rsp_bin_re;
            got_bin.im = rsp_bin_im;
            if (bins_due.size() == 0) begin
               report_bad("bin beat with none due", got_bin.re, 0);
            end else begin
               want_bin = bins_due.pop_front();
               if (got_bin.re !== want_bin.re) report_bad("bin_re", got_bin.re, want_bin.re);
               if (got_bin.im !== want_bin.im) report_bad("bin_im", got_bin.im, want_bin.im);
            end
         end
         if (req_valid && req_ready) begin
            addr = int'(req_index) & (NPTS - 1);
            case (req_operation)
               OP_LOAD: begin
                  spec_re[addr] = req_point_re;
                  spec_im[addr] = req_point_im;
               end
               OP_XFORM: compute_spectrum();
               OP_READ: begin
                  want_bin.re = spec_re[addr];
                  want_bin.im = spec_im[addr];
                  bins_due.push_back(want_bin);
               end
               default: ;
            endcase
         end
         pending = bins_due.size();
      end
   end

endmodule

// File: tb/sv/radix2_dif_fft_test.sv
// Top of the FFT testbench: clock, reset, beat stimulus, receiver stalls and verdict.
module radix2_dif_fft_test;
   import r2fft_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LOG2_POINTS = 10;
   localparam int NPTS = 1 << LOG2_POINTS;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;
   localparam int IDLE_LIMIT = 100000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_operation = OP_NONE;
   logic [IDX_W-1:0]          req_index = '0;
   logic signed [PT_W-1:0]    req_point_re = '0;
   logic signed [PT_W-1:0]    req_point_im = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [WORD_W-1:0]  rsp_bin_re;
   logic signed [WORD_W-1:0]  rsp_bin_im;
   int                        fail_count;
   int                        pending;
   bit                        quiet = 1'b0;
   bit                        hold_req = 1'b0;
   int                        idle_cycles = 0;
   int                        n_load = 0;
   int                        n_xform = 0;
   int                        n_read = 0;
   int                        n_other = 0;

   radix2_dif_fft #(.LOG2_POINTS(LOG2_POINTS)) u_top (.*);

   radix2_dif_fft_checker #(.LOG2_POINTS(LOG2_POINTS)) u_checker (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles without a beat", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_req = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic issue(input logic [OP_W-1:0] op, input int idx,
                        input logic [PT_W-1:0] re, input logic [PT_W-1:0] im);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_index     <= idx[IDX_W-1:0];
      req_point_re  <= re;
      req_point_im  <= im;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      case (op)
         OP_LOAD:  n_load++;
         OP_XFORM: n_xform++;
         OP_READ:  n_read++;
         default:  n_other++;
      endcase
   endtask

   function automatic logic [PT_W-1:0] pick_sample();
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return PT_W'($urandom);
      endcase
   endfunction

   task automatic random_beat();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) issue(OP_LOAD, $urandom_range(0, NPTS - 1), pick_sample(), pick_sample());
      else if (r < 95) issue(OP_READ, $urandom_range(0, NPTS - 1), pick_sample(), pick_sample());
      else issue(OP_NONE, $urandom_range(0, NPTS - 1), pick_sample(), pick_sample());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes, ignored code, reads of loaded entries only
      issue(OP_NONE, NPTS - 1, 16'h7fff, 16'h8000);
      issue(OP_LOAD, 0, 16'h7fff, 16'h8000);
      issue(OP_LOAD, NPTS - 1, 16'h8000, 16'h7fff);
      issue(OP_LOAD, 512, 16'h0000, 16'hffff);
      issue(OP_READ, 0, 16'h0000, 16'h0000);
      issue(OP_READ, NPTS - 1, 16'hffff, 16'hffff);
      issue(OP_READ, 512, 16'h0000, 16'h0000);
      issue(OP_NONE, 0, 16'h1234, 16'h4321);
      issue(OP_READ, 0, 16'h0000, 16'h0000);

      // full frame: all points written before any transform
      for (int i = 0; i < NPTS; i++) begin
         if (i < 4) issue(OP_LOAD, i, 16'h7fff, 16'h7fff);
         else issue(OP_LOAD, i, pick_sample(), pick_sample());
      end
      issue(OP_XFORM, 0, 16'h0000, 16'h0000);
      issue(OP_READ, 0, 16'h0000, 16'h0000);
      issue(OP_READ, 1, 16'h0000, 16'h0000);
      issue(OP_READ, NPTS - 1, 16'h0000, 16'h0000);

      // long receiver hold-off while reads keep coming
      hold_req = 1'b1;
      repeat (40) issue(OP_READ, $urandom_range(0, NPTS - 1), pick_sample(), pick_sample());

      for (int blk = 0; blk < 6; blk++) begin
         if (blk == 5) quiet = 1'b1;
         repeat (120) random_beat();
         issue(OP_XFORM, $urandom_range(0, NPTS - 1), pick_sample(), pick_sample());
         repeat (30) issue(OP_READ, $urandom_range(0, NPTS - 1), pick_sample(), pick_sample());
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d loads, %0d transforms, %0d bin reads, %0d ignored beats",
               n_load, n_xform, n_read, n_other);
      $display("with random stalls on both sides and one long receiver hold-off");
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: radix2_dif_fft.f
+incdir+rtl
rtl/r2fft_pkg.sv
rtl/r2fft_ram.sv
rtl/r2fft_twiddle.sv
rtl/r2fft_bfly.sv
rtl/radix2_dif_fft.sv
tb/sv/radix2_dif_fft_checker.sv
tb/sv/radix2_dif_fft_test.sv
